### design/ncv_pkg.sv
package ncv_pkg;

    localparam int POS_W  = 32;
    localparam int TAN_W  = 16;
    localparam int IDX_W  = 7;
    localparam int CNT_W  = 8;
    localparam int R2_W   = 64;
    localparam int OPD_W  = POS_W + 1;
    localparam int PRD_W  = 2 * OPD_W;
    localparam int DVD_W  = 81;
    localparam int MAG_W  = 17;
    localparam int STEP_W = $clog2(DVD_W);

    localparam logic [CNT_W-1:0] COUNT_RESET = 8'd90;
    localparam logic [R2_W-1:0]  ONE_Q32     = 64'h0000_0001_0000_0000;
    localparam logic [DVD_W-1:0] DVD_ONE     = {1'b1, {(DVD_W-1){1'b0}}};

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TAN_W-1:0] tan_x;
        logic signed [TAN_W-1:0] tan_y;
        logic signed [TAN_W-1:0] tan_z;
    } coil_entry_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [R2_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

### design/ncv_table.sv
module ncv_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  ncv_pkg::coil_entry_t wr_data,
    input  logic [AW-1:0]       rd_addr,
    output ncv_pkg::coil_entry_t rd_data
);

    ncv_pkg::coil_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### design/ncv_mul.sv
module ncv_mul (
    input  logic                              clk,
    input  logic signed [ncv_pkg::OPD_W-1:0]  op_a,
    input  logic signed [ncv_pkg::OPD_W-1:0]  op_b,
    output logic signed [ncv_pkg::PRD_W-1:0]  prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

endmodule

### design/ncv_div.sv
module ncv_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ncv_pkg::div_req_t req,
    output ncv_pkg::div_rsp_t rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [ncv_pkg::STEP_W-1:0]  step_reg;
    logic [ncv_pkg::DVD_W-1:0]   dq_reg;
    logic [ncv_pkg::R2_W-1:0]    rem_reg;
    logic [ncv_pkg::R2_W-1:0]    divisor_reg;

    logic [ncv_pkg::R2_W:0]      shifted;
    logic [ncv_pkg::R2_W:0]      trial;
    logic                        fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted = {rem_reg, dq_reg[ncv_pkg::DVD_W-1]};
        trial   = shifted - {1'b0, divisor_reg};
        fits    = shifted >= {1'b0, divisor_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= ncv_pkg::STEP_W'(ncv_pkg::DVD_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg      <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[ncv_pkg::DVD_W-2:0], fits};
            rem_reg <= fits ? trial[ncv_pkg::R2_W-1:0] : shifted[ncv_pkg::R2_W-1:0];
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

### design/nearest_coil_vorticity.sv
// Nearest coil point vorticity. A load transfer (mode 0) writes one coil entry (Q16.16 position,
// Q1.14 tangent) into the table; a load with an index at or beyond MAX_COILS is dropped. A query
// transfer (mode 1) scans the first coil_count entries (0 counts as 1, values above MAX_COILS as
// MAX_COILS) for the least saturated squared distance, lowest index on a tie, and returns that
// index with the tangent scaled by floor(2^80 / (r2 + 1.0)^2). Each scanned entry passes through
// the table read port and the one shared 33x33 multiplier, then come two 81-step passes of the
// bit-serial divider and the scaling on the same multiplier. The input is not ready while a
// query is in progress; a finished result sits in the output register while the next transfer
// is taken. Entries must be loaded before a query reaches them. coil_count is written through
// cfg_wr_en / cfg_wr_data and resets to 90.
module nearest_coil_vorticity #(
    parameter int MAX_COILS = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ncv_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [ncv_pkg::IDX_W-1:0]         entry_index,
    input  logic signed [ncv_pkg::POS_W-1:0]  pos_x,
    input  logic signed [ncv_pkg::POS_W-1:0]  pos_y,
    input  logic signed [ncv_pkg::POS_W-1:0]  pos_z,
    input  logic signed [ncv_pkg::TAN_W-1:0]  tan_x,
    input  logic signed [ncv_pkg::TAN_W-1:0]  tan_y,
    input  logic signed [ncv_pkg::TAN_W-1:0]  tan_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ncv_pkg::IDX_W-1:0]         nearest_index,
    output logic signed [ncv_pkg::TAN_W-1:0]  vort_x,
    output logic signed [ncv_pkg::TAN_W-1:0]  vort_y,
    output logic signed [ncv_pkg::TAN_W-1:0]  vort_z
);

    localparam int AW = (MAX_COILS > 1) ? $clog2(MAX_COILS) : 1;
    localparam int NW = ($clog2(MAX_COILS + 1) > ncv_pkg::CNT_W) ?
                        $clog2(MAX_COILS + 1) : ncv_pkg::CNT_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_COILS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_DX     = 4'd2;
    localparam logic [3:0] S_DY     = 4'd3;
    localparam logic [3:0] S_DZ     = 4'd4;
    localparam logic [3:0] S_DW     = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_DIV1   = 4'd7;
    localparam logic [3:0] S_DIV1_W = 4'd8;
    localparam logic [3:0] S_DIV2   = 4'd9;
    localparam logic [3:0] S_DIV2_W = 4'd10;
    localparam logic [3:0] S_SX     = 4'd11;
    localparam logic [3:0] S_SY     = 4'd12;
    localparam logic [3:0] S_SZ     = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0]                      state_reg;
    logic [3:0]                      state_next;
    logic [ncv_pkg::CNT_W-1:0]       coil_count_reg;
    logic                            out_valid_reg;
    logic [AW-1:0]                   idx_reg;
    logic [AW-1:0]                   last_reg;
    logic [AW-1:0]                   best_reg;

    logic signed [ncv_pkg::POS_W-1:0] qx_reg;
    logic signed [ncv_pkg::POS_W-1:0] qy_reg;
    logic signed [ncv_pkg::POS_W-1:0] qz_reg;
    logic signed [ncv_pkg::OPD_W-1:0] diff_reg;
    logic [ncv_pkg::R2_W-1:0]         acc_reg;
    logic [ncv_pkg::R2_W-1:0]         bestd_reg;
    logic signed [ncv_pkg::TAN_W-1:0] btan_x_reg;
    logic signed [ncv_pkg::TAN_W-1:0] btan_y_reg;
    logic signed [ncv_pkg::TAN_W-1:0] btan_z_reg;
    logic [ncv_pkg::MAG_W-1:0]        mag_reg;
    logic signed [ncv_pkg::TAN_W-1:0] vx_reg;
    logic signed [ncv_pkg::TAN_W-1:0] vy_reg;
    logic [ncv_pkg::IDX_W-1:0]        nearest_index_reg;
    logic signed [ncv_pkg::TAN_W-1:0] vort_x_reg;
    logic signed [ncv_pkg::TAN_W-1:0] vort_y_reg;
    logic signed [ncv_pkg::TAN_W-1:0] vort_z_reg;

    logic                             accept;
    logic                             out_free;
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    ncv_pkg::coil_entry_t             wr_data;
    logic [AW-1:0]                    rd_addr;
    ncv_pkg::coil_entry_t             rd_data;

    logic signed [ncv_pkg::OPD_W-1:0] op_a;
    logic signed [ncv_pkg::OPD_W-1:0] op_b;
    logic signed [ncv_pkg::PRD_W-1:0] prod;
    logic [ncv_pkg::R2_W-1:0]         sq;
    logic [ncv_pkg::R2_W:0]           acc_sum;
    logic [ncv_pkg::R2_W-1:0]         acc_sat;
    logic [ncv_pkg::R2_W:0]           s_sum;
    logic [ncv_pkg::R2_W-1:0]         s_sat;
    logic signed [ncv_pkg::POS_W-1:0] q_sel;
    logic signed [ncv_pkg::POS_W-1:0] r_sel;
    logic signed [ncv_pkg::OPD_W-1:0] diff_calc;
    logic signed [ncv_pkg::TAN_W-1:0] tan_sel;
    logic [NW-1:0]                    n_raw;
    logic [NW-1:0]                    n_clip;

    ncv_pkg::div_req_t                div_req;
    ncv_pkg::div_rsp_t                div_rsp;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // table
    assign wr_en   = accept && (mode == ncv_pkg::MODE_LOAD) && (32'(entry_index) < MAX_COILS);
    assign wr_addr = AW'(entry_index);
    assign wr_data = '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                       tan_x: tan_x, tan_y: tan_y, tan_z: tan_z};
    assign rd_addr = (state_reg == S_CMP) ? idx_reg + AW'(1) : idx_reg;

    ncv_table #(
        .DEPTH (MAX_COILS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared multiplier: squares during the scan, tangent scaling at the end
    always_comb
    begin
        unique case (state_reg)
            S_SX:    tan_sel = btan_x_reg;
            S_SY:    tan_sel = btan_y_reg;
            default: tan_sel = btan_z_reg;
        endcase
        if (state_reg == S_SX || state_reg == S_SY || state_reg == S_SZ || state_reg == S_OUT)
        begin
            op_a = $signed({{(ncv_pkg::OPD_W - ncv_pkg::MAG_W){1'b0}}, mag_reg});
            op_b = ncv_pkg::OPD_W'(tan_sel);
        end
        else
        begin
            op_a = diff_reg;
            op_b = diff_reg;
        end
    end

    ncv_mul u_mul (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod)
    );

    always_comb
    begin
        unique case (state_reg)
            S_DY:
            begin
                q_sel = qy_reg;
                r_sel = rd_data.pos_y;
            end
            S_DZ:
            begin
                q_sel = qz_reg;
                r_sel = rd_data.pos_z;
            end
            default:
            begin
                q_sel = qx_reg;
                r_sel = rd_data.pos_x;
            end
        endcase
        diff_calc = ncv_pkg::OPD_W'(q_sel) - ncv_pkg::OPD_W'(r_sel);
        sq        = prod[ncv_pkg::R2_W-1:0];
        acc_sum   = {1'b0, acc_reg} + {1'b0, sq};
        acc_sat   = acc_sum[ncv_pkg::R2_W] ? '1 : acc_sum[ncv_pkg::R2_W-1:0];
        s_sum     = {1'b0, bestd_reg} + {1'b0, ncv_pkg::ONE_Q32};
        s_sat     = s_sum[ncv_pkg::R2_W] ? '1 : s_sum[ncv_pkg::R2_W-1:0];
        n_raw     = NW'(coil_count_reg);
        if (n_raw == '0)
        begin
            n_clip = NW'(1);
        end
        else if (n_raw > MAX_N)
        begin
            n_clip = MAX_N;
        end
        else
        begin
            n_clip = n_raw;
        end
    end

    // divider: first 2^80 / s, then that quotient / s
    assign div_req.start    = (state_reg == S_DIV1) || (state_reg == S_DIV2);
    assign div_req.dividend = (state_reg == S_DIV1) ? ncv_pkg::DVD_ONE : div_rsp.quotient;
    assign div_req.divisor  = s_sat;

    ncv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && mode == ncv_pkg::MODE_QUERY)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:     state_next = S_DX;
            S_DX:     state_next = S_DY;
            S_DY:     state_next = S_DZ;
            S_DZ:     state_next = S_DW;
            S_DW:     state_next = S_CMP;
            S_CMP:    state_next = (idx_reg == last_reg) ? S_DIV1 : S_DX;
            S_DIV1:   state_next = S_DIV1_W;
            S_DIV1_W: state_next = div_rsp.done ? S_DIV2 : S_DIV1_W;
            S_DIV2:   state_next = S_DIV2_W;
            S_DIV2_W: state_next = div_rsp.done ? S_SX : S_DIV2_W;
            S_SX:     state_next = S_SY;
            S_SY:     state_next = S_SZ;
            S_SZ:     state_next = S_OUT;
            S_OUT:    state_next = out_free ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            coil_count_reg <= ncv_pkg::COUNT_RESET;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                coil_count_reg <= cfg_wr_data;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == S_CMP && idx_reg != last_reg)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg   <= pos_x;
            qy_reg   <= pos_y;
            qz_reg   <= pos_z;
            last_reg <= AW'(n_clip - NW'(1));
        end
        if (state_reg == S_DX || state_reg == S_DY || state_reg == S_DZ)
        begin
            diff_reg <= diff_calc;
        end
        if (state_reg == S_DZ)
        begin
            acc_reg <= sq;
        end
        else if (state_reg == S_DW)
        begin
            acc_reg <= acc_sat;
        end
        if (state_reg == S_CMP && (idx_reg == '0 || acc_sat < bestd_reg))
        begin
            best_reg   <= idx_reg;
            bestd_reg  <= acc_sat;
            btan_x_reg <= rd_data.tan_x;
            btan_y_reg <= rd_data.tan_y;
            btan_z_reg <= rd_data.tan_z;
        end
        if (state_reg == S_DIV2_W && div_rsp.done)
        begin
            mag_reg <= div_rsp.quotient[ncv_pkg::MAG_W-1:0];
        end
        if (state_reg == S_SY)
        begin
            vx_reg <= prod[2*ncv_pkg::TAN_W-1:ncv_pkg::TAN_W];
        end
        if (state_reg == S_SZ)
        begin
            vy_reg <= prod[2*ncv_pkg::TAN_W-1:ncv_pkg::TAN_W];
        end
        if (state_reg == S_OUT && out_free)
        begin
            nearest_index_reg <= ncv_pkg::IDX_W'(best_reg);
            vort_x_reg        <= vx_reg;
            vort_y_reg        <= vy_reg;
            vort_z_reg        <= prod[2*ncv_pkg::TAN_W-1:ncv_pkg::TAN_W];
        end
    end

    assign out_valid     = out_valid_reg;
    assign nearest_index = nearest_index_reg;
    assign vort_x        = vort_x_reg;
    assign vort_y        = vort_y_reg;
    assign vort_z        = vort_z_reg;

    // checks
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while idle");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output step");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (idx_reg <= last_reg))
        else $error("scan index past last entry");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV1_W || state_reg == S_DIV2_W))
        else $error("divider finished with no one waiting");

endmodule

### sim/coil_vorticity_checker.sv
`timescale 1ns / 1ps
module coil_vorticity_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [ncv_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             mode,
    input  logic [ncv_pkg::IDX_W-1:0]        entry_index,
    input  logic signed [ncv_pkg::POS_W-1:0] pos_x,
    input  logic signed [ncv_pkg::POS_W-1:0] pos_y,
    input  logic signed [ncv_pkg::POS_W-1:0] pos_z,
    input  logic signed [ncv_pkg::TAN_W-1:0] tan_x,
    input  logic signed [ncv_pkg::TAN_W-1:0] tan_y,
    input  logic signed [ncv_pkg::TAN_W-1:0] tan_z,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [ncv_pkg::IDX_W-1:0]        nearest_index,
    input  logic signed [ncv_pkg::TAN_W-1:0] vort_x,
    input  logic signed [ncv_pkg::TAN_W-1:0] vort_y,
    input  logic signed [ncv_pkg::TAN_W-1:0] vort_z,
    output int                               outstanding,
    output int                               fail_count,
    output int                               results_checked
);
    import ncv_pkg::*;

    localparam int TABLE_DEPTH = 128;

    typedef struct packed {
        logic [IDX_W-1:0]        coil;
        logic signed [TAN_W-1:0] vx;
        logic signed [TAN_W-1:0] vy;
        logic signed [TAN_W-1:0] vz;
    } vorticity_t;

    coil_entry_t      coil_table [TABLE_DEPTH];
    logic [CNT_W-1:0] scan_limit;
    vorticity_t       expected_vort_q [$];
    int               errors = 0;
    int               checked = 0;

    function automatic logic [R2_W-1:0] square_gap(input logic signed [POS_W-1:0] a, b);
        logic signed [OPD_W-1:0] d;
        logic [R2_W-1:0]         m;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        if (d < 0)
            d = -d;
        m = R2_W'(d);
        return m * m;
    endfunction

    function automatic logic [R2_W-1:0] add_clamped(input logic [R2_W-1:0] a, b);
        logic [R2_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[R2_W] ? '1 : s[R2_W-1:0];
    endfunction

    function automatic logic signed [TAN_W-1:0] scale_tangent(input logic [MAG_W-1:0] mag,
                                                              input logic signed [TAN_W-1:0] t);
        logic signed [MAG_W+TAN_W:0] p;
        p = $signed({1'b0, mag}) * t;
        return p[TAN_W+15:16];
    endfunction

    function automatic vorticity_t predict_vorticity(input logic signed [POS_W-1:0] qx, qy, qz);
        int               n;
        int               i;
        int               best;
        logic [R2_W-1:0]  r2;
        logic [R2_W-1:0]  best_r2;
        logic [R2_W-1:0]  s_q32;
        logic [127:0]     denom;
        logic [127:0]     quot;
        logic [MAG_W-1:0] mag;
        vorticity_t       v;
        n = (scan_limit == 0) ? 1 :
            ((int'(scan_limit) > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_limit));
        best = 0;
        best_r2 = '0;
        for (i = 0; i < n; i++)
        begin
            r2 = add_clamped(add_clamped(square_gap(coil_table[i].pos_x, qx),
                                         square_gap(coil_table[i].pos_y, qy)),
                             square_gap(coil_table[i].pos_z, qz));
            if (i == 0 || r2 < best_r2)
            begin
                best = i;
                best_r2 = r2;
            end
        end
        // mag = 2^80 / (r2 + 1.0)^2, with r2 and r2 + 1.0 in q32.32
        s_q32 = add_clamped(best_r2, ONE_Q32);
        denom = {64'd0, s_q32} * {64'd0, s_q32};
        quot = (128'd1 << 80) / denom;
        mag = quot[MAG_W-1:0];
        v.coil = IDX_W'(best);
        v.vx = scale_tangent(mag, coil_table[best].tan_x);
        v.vy = scale_tangent(mag, coil_table[best].tan_y);
        v.vz = scale_tangent(mag, coil_table[best].tan_z);
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        vorticity_t want;
        if (!rst_n)
        begin
            scan_limit = COUNT_RESET;
            expected_vort_q.delete();
            outstanding <= 0;
            fail_count <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                scan_limit = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (expected_vort_q.size() == 0)
                begin
                    $error("unexpected result transfer: nearest_index %0d", nearest_index);
                    errors++;
                end
                else
                begin
                    want = expected_vort_q.pop_front();
                    checked++;
                    if (nearest_index !== want.coil)
                    begin
                        $error("nearest_index: expected %0d, got %0d", want.coil, nearest_index);
                        errors++;
                    end
                    if (vort_x !== want.vx)
                    begin
                        $error("vort_x: expected %0d, got %0d", $signed(want.vx), vort_x);
                        errors++;
                    end
                    if (vort_y !== want.vy)
                    begin
                        $error("vort_y: expected %0d, got %0d", $signed(want.vy), vort_y);
                        errors++;
                    end
                    if (vort_z !== want.vz)
                    begin
                        $error("vort_z: expected %0d, got %0d", $signed(want.vz), vort_z);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (mode == MODE_QUERY)
                    expected_vort_q.push_back(predict_vorticity(pos_x, pos_y, pos_z));
                else
                begin
                    coil_table[entry_index].pos_x = pos_x;
                    coil_table[entry_index].pos_y = pos_y;
                    coil_table[entry_index].pos_z = pos_z;
                    coil_table[entry_index].tan_x = tan_x;
                    coil_table[entry_index].tan_y = tan_y;
                    coil_table[entry_index].tan_z = tan_z;
                end
            end
            outstanding <= expected_vort_q.size();
            fail_count <= errors;
            results_checked <= checked;
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ncv_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int LONG_HOLD   = 2000;
    localparam int SETTLE      = 16;
    localparam int NUM_PHASES  = 16;

    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [TAN_W-1:0] TAN_MIN = 16'sh8000;
    localparam logic signed [TAN_W-1:0] TAN_MAX = 16'sh7fff;
    localparam logic signed [POS_W-1:0] UNIT    = 32'sh0001_0000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]        cfg_wr_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    mode = MODE_LOAD;
    logic [IDX_W-1:0]        entry_index = '0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic signed [TAN_W-1:0] tan_x = '0;
    logic signed [TAN_W-1:0] tan_y = '0;
    logic signed [TAN_W-1:0] tan_z = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [IDX_W-1:0]        nearest_index;
    logic signed [TAN_W-1:0] vort_x;
    logic signed [TAN_W-1:0] vort_y;
    logic signed [TAN_W-1:0] vort_z;
    int                      outstanding;
    int                      fail_count;
    int                      results_checked;
    logic                    hold_request = 1'b0;

    logic [TABLE_DEPTH-1:0]  loaded = '0;
    logic signed [POS_W-1:0] seen_x [TABLE_DEPTH];
    logic signed [POS_W-1:0] seen_y [TABLE_DEPTH];
    logic signed [POS_W-1:0] seen_z [TABLE_DEPTH];
    int                      scan_n = 90;
    int                      burst_left = 8;
    int                      gap_max = 3;
    int                      load_total = 0;
    int                      query_total = 0;
    int                      setting_total = 0;

    nearest_coil_vorticity dut (.*);

    coil_vorticity_checker checker_i (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic signed [POS_W-1:0] jitter(input logic signed [POS_W-1:0] base,
                                                       input int spread);
        int off;
        off = int'($urandom_range(0, 2 * spread)) - spread;
        return base + off;
    endfunction

    function automatic logic signed [POS_W-1:0] corner_pos();
        case ($urandom_range(0, 3))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [TAN_W-1:0] corner_tan();
        case ($urandom_range(0, 5))
            0: return TAN_MIN;
            1: return TAN_MAX;
            2: return 16'sd16384;
            3: return -16'sd16384;
            4: return -16'sd1;
            default: return '0;
        endcase
    endfunction

    task automatic send_item(input logic m, input logic [IDX_W-1:0] e,
                             input logic signed [POS_W-1:0] x, y, z,
                             input logic signed [TAN_W-1:0] a, b, c);
        mode <= m;
        entry_index <= e;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        tan_x <= a;
        tan_y <= b;
        tan_z <= c;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (m == MODE_LOAD)
        begin
            loaded[e] = 1'b1;
            seen_x[e] = x;
            seen_y[e] = y;
            seen_z[e] = z;
            load_total++;
        end
        else
            query_total++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
    endtask

    // wait until every query has been answered, then let a trailing load settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_count(input logic [CNT_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        scan_n = (v == 0) ? 1 : ((int'(v) > TABLE_DEPTH) ? TABLE_DEPTH : int'(v));
        setting_total++;
    endtask

    task automatic random_item();
        int                      pick;
        int                      k;
        int                      e;
        int                      spread;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, scan_n - 1);
        spread = ($urandom_range(0, 3) == 0) ? 64 : (1 << 17);
        if (pick < 45)
            send_item(MODE_QUERY, IDX_W'($urandom), jitter(seen_x[k], spread),
                      jitter(seen_y[k], spread), jitter(seen_z[k], spread),
                      TAN_W'($urandom), TAN_W'($urandom), TAN_W'($urandom));
        else if (pick < 55)
            send_item(MODE_QUERY, IDX_W'($urandom), seen_x[k], seen_y[k], seen_z[k],
                      TAN_W'($urandom), TAN_W'($urandom), TAN_W'($urandom));
        else if (pick < 65)
            send_item(MODE_QUERY, IDX_W'($urandom), $urandom, $urandom, $urandom,
                      TAN_W'($urandom), TAN_W'($urandom), TAN_W'($urandom));
        else if (pick < 95)
        begin
            e = ($urandom_range(0, 9) < 7) ? $urandom_range(0, scan_n - 1)
                                           : $urandom_range(0, TABLE_DEPTH - 1);
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end
                3, 4, 5:
                begin
                    x = seen_x[k];
                    y = seen_y[k];
                    z = seen_z[k];
                end
                default:
                begin
                    x = jitter('0, 1 << 18);
                    y = jitter('0, 1 << 18);
                    z = jitter('0, 1 << 18);
                end
            endcase
            send_item(MODE_LOAD, IDX_W'(e), x, y, z,
                      TAN_W'($urandom), TAN_W'($urandom), TAN_W'($urandom));
        end
        else
            send_item(MODE_LOAD, IDX_W'($urandom_range(0, scan_n - 1)),
                      corner_pos(), corner_pos(), corner_pos(),
                      corner_tan(), corner_tan(), corner_tan());
    endtask

    // output side: stall pattern of its own plus one long hold
    initial
    begin : receiver
        int   seg_len;
        int   style;
        logic hold_served;
        hold_served = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_request && !hold_served)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served = 1'b1;
            end
            seg_len = $urandom_range(1, 120);
            style = $urandom_range(0, 3);
            repeat (seg_len)
            begin
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ~out_ready;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int               ph;
        int               i;
        int               e;
        int               budget;
        logic [CNT_W-1:0] setting;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count of zero searches entry 0 only
        set_count(8'd0);
        send_item(MODE_LOAD, 7'd0, POS_MIN, POS_MIN, POS_MIN, TAN_MIN, TAN_MAX, 16'sd0);
        send_item(MODE_QUERY, 7'd0, POS_MAX, POS_MAX, POS_MAX, '0, '0, '0);
        send_item(MODE_QUERY, 7'd127, POS_MIN, POS_MIN, POS_MIN, TAN_MAX, TAN_MAX, TAN_MAX);
        send_item(MODE_LOAD, 7'd0, '0, '0, '0, TAN_MAX, TAN_MIN, -16'sd1);
        send_item(MODE_QUERY, 7'd0, 32'sd1, '0, '0, '0, '0, '0);
        send_item(MODE_QUERY, 7'd0, UNIT, '0, '0, '0, '0, '0);

        // ties and fully saturated distances over four entries
        set_count(8'd4);
        for (i = 0; i < 4; i++)
            send_item(MODE_LOAD, IDX_W'(i), POS_MIN, POS_MIN, POS_MIN, TAN_W'(i * 12000 - 20000),
                      TAN_W'(15000 - i * 9000), TAN_W'(i * 7000));
        send_item(MODE_QUERY, 7'd0, POS_MAX, POS_MAX, POS_MAX, '0, '0, '0);
        send_item(MODE_QUERY, 7'd0, POS_MIN, POS_MIN, POS_MIN, '0, '0, '0);
        send_item(MODE_LOAD, 7'd2, 5 * UNIT, -3 * UNIT, 7 * UNIT, -16'sd16384, 16'sd16384,
                  16'sd11585);
        send_item(MODE_QUERY, 7'd0, 5 * UNIT + 3, -3 * UNIT, 7 * UNIT, '0, '0, '0);
        send_item(MODE_LOAD, 7'd127, POS_MAX, POS_MAX, POS_MAX, -16'sd1, -16'sd1, -16'sd1);
        send_item(MODE_LOAD, 7'd3, POS_MAX, POS_MAX, POS_MAX - 1, 16'sd1, 16'sd2, 16'sd3);
        send_item(MODE_QUERY, 7'd0, POS_MAX, POS_MAX, POS_MAX, '0, '0, '0);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: setting = 8'd1;
                3: setting = 8'd90;
                7: setting = 8'd255;
                11: setting = 8'd128;
                14: setting = 8'd0;
                default: setting = CNT_W'($urandom_range(1, 16));
            endcase
            set_count(setting);
            gap_max = (ph % 4 == 2) ? 0 : $urandom_range(2, 20);
            if (ph == 5)
                hold_request <= 1'b1;
            for (e = 0; e < scan_n; e++)
                if (!loaded[e])
                    send_item(MODE_LOAD, IDX_W'(e), jitter('0, 1 << 18), jitter('0, 1 << 18),
                              jitter('0, 1 << 18), TAN_W'($urandom), TAN_W'($urandom),
                              TAN_W'($urandom));
            budget = (scan_n > 32) ? 35 : 130;
            for (i = 0; i < budget; i++)
            begin
                if (ph == 9 && i == budget / 2)
                    drain();
                random_item();
            end
        end
        drain();

        $display("covered %0d loads and %0d queries over %0d count settings (0, 1, 90, 128, 255)",
                 load_total, query_total, setting_total);
        $display("%0d results compared, including a long output hold and mid-run drains",
                 results_checked);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
